FILE: rtl/core/pdlf_pkg.sv
// ----------------------------------------------------------------------------
// PD line follower motor mixer package
// Shared widths, register codes, drive modes and interface structures.
// ----------------------------------------------------------------------------
package pdlf_pkg;

  localparam int unsigned ErrW     = 13;
  localparam int unsigned GainW    = 24;
  localparam int unsigned DutyW    = 8;
  localparam int unsigned ThrW     = 12;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned MulW     = 24;
  localparam int unsigned ProdW    = 2 * MulW;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPropGain  = 3'd0,
    CfgDerivGain = 3'd1,
    CfgBaseSpeed = 3'd2,
    CfgSpinSpeed = 3'd3,
    CfgSpinThr   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ModeTrack   = 2'd0,
    ModeSpinPos = 2'd1,
    ModeSpinNeg = 2'd2
  } mode_e;

  typedef struct packed {
    logic [GainW-1:0] prop_gain;
    logic [GainW-1:0] deriv_gain;
    logic [DutyW-1:0] base_speed;
    logic [DutyW-1:0] spin_speed;
    logic [ThrW-1:0]  spin_threshold;
  } cfg_t;

  typedef struct packed {
    logic            load;
    logic [MulW-1:0] op_a;
    logic [MulW-1:0] op_b;
  } mul_req_t;

endpackage

FILE: rtl/core/pd_line_follow_motor_mixer_top.sv
// ----------------------------------------------------------------------------
// PD line follower motor mixer
// Channel  | Direction | Handshake            | Payload
// in       | in        | in_valid_i/in_stall_o | line_error_i, time_step_i
// out      | out       | out_valid_o/out_stall_i | motor_a/b_dir_o, motor_a/b_duty_o,
//          |           |                      | drive_mode_o
// cfg      | in        | cfg_we_i             | cfg_idx_i, cfg_wdata_i
// A transaction passes four times through the shared multiplier, then through the
// saturate, sum and clamp steps, before it reaches the result register.
// The sequencer is idle again once the result is loaded; input is stalled until then.
// Reset restores the register defaults and clears the stored error.
// A stalled result holds the sequencer in its last step and so stalls the input.
// ----------------------------------------------------------------------------
module pd_line_follow_motor_mixer_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pdlf_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [pdlf_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [pdlf_pkg::ErrW-1:0] line_error_i,
  input  logic [23:0]                      time_step_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             motor_a_dir_o,
  output logic                             motor_b_dir_o,
  output logic [7:0]                       motor_a_duty_o,
  output logic [7:0]                       motor_b_duty_o,
  output logic [1:0]                       drive_mode_o
);
  import pdlf_pkg::*;

  localparam int unsigned DiffW  = ErrW + 1;
  localparam int unsigned CmpW   = ((ErrW > ThrW) ? ErrW : ThrW) + 2;
  localparam int unsigned PMagW  = GainW + ErrW;
  localparam int unsigned FracW  = 32;
  localparam int unsigned TurnW  = 62;
  localparam int unsigned SatBit = 58;
  localparam int unsigned HiKeep = SatBit - MulW;

  localparam logic [SatBit:0] DerivLimit = {1'b1, {SatBit{1'b0}}};
  localparam logic signed [TurnW-1:0] DutyMaxQ =
    {{(TurnW-DutyW-FracW){1'b0}}, {DutyW{1'b1}}, {FracW{1'b0}}};

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StProp  = 8'b0000_0010,
    StDeriv = 8'b0000_0100,
    StLo    = 8'b0000_1000,
    StHi    = 8'b0001_0000,
    StSat   = 8'b0010_0000,
    StTurn  = 8'b0100_0000,
    StOut   = 8'b1000_0000
  } state_e;

  function automatic logic [DutyW-1:0] clamp_duty(input logic signed [TurnW-1:0] q);
    logic [DutyW-1:0] r;
    if (q <= 0) begin
      r = '0;
    end else if (q >= DutyMaxQ) begin
      r = {DutyW{1'b1}};
    end else begin
      r = q[FracW+DutyW-1:FracW];
    end
    return r;
  endfunction

  cfg_t     cfg;
  mul_req_t mul_req;
  logic [ProdW-1:0] prod;

  state_e state_q, state_d;

  logic signed [ErrW-1:0] prev_q;
  logic [ErrW-1:0]        eabs_q;
  logic                   eneg_q;
  logic [23:0]            step_q;
  logic [DiffW-1:0]       adiff_q;
  logic                   dneg_q;
  mode_e                  mode_q;
  logic                   emit_q;
  logic [MulW-1:0]        mhi_q;
  logic [ProdW-1:0]       lo_q;
  logic signed [TurnW-1:0] pterm_q, dterm_q, turn_q;

  logic                   out_valid_q;
  logic                   a_dir_q, b_dir_q;
  logic [DutyW-1:0]       a_duty_q, b_duty_q;
  mode_e                  out_mode_q;

  logic                   accept;
  logic signed [DiffW-1:0] diff;
  logic signed [CmpW-1:0] err_c, thr_c;
  logic                   in_band, spin_pos, spin_neg;
  logic [SatBit:0]        dsum, dmag;
  logic                   dsat;
  logic signed [TurnW-1:0] pterm_d, dterm_d, base_q, duty_a_q32, duty_b_q32;
  logic                   out_load;

  pdlf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pdlf_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;

  // Decisions on the incoming transaction.
  assign diff    = DiffW'(line_error_i) - DiffW'(prev_q);
  assign err_c   = CmpW'(line_error_i);
  assign thr_c   = signed'(CmpW'(cfg.spin_threshold));
  assign in_band = (err_c < thr_c) && (err_c > -thr_c);
  assign spin_pos = err_c > thr_c;
  assign spin_neg = err_c < -thr_c;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_req = '0;
    unique case (state_q)
      StProp: begin
        mul_req.load = 1'b1;
        mul_req.op_a = cfg.prop_gain;
        mul_req.op_b = MulW'(eabs_q);
      end
      StDeriv: begin
        mul_req.load = 1'b1;
        mul_req.op_a = cfg.deriv_gain;
        mul_req.op_b = step_q;
      end
      StLo: begin
        mul_req.load = 1'b1;
        mul_req.op_a = prod[MulW-1:0];
        mul_req.op_b = MulW'(adiff_q);
      end
      StHi: begin
        mul_req.load = 1'b1;
        mul_req.op_a = mhi_q;
        mul_req.op_b = MulW'(adiff_q);
      end
      default: mul_req = '0;
    endcase
  end

  // The proportional product is Q16, shifted up to the common Q32 format.
  assign pterm_d = eneg_q ? -(TurnW'(prod[PMagW-1:0]) << 16)
                          :  (TurnW'(prod[PMagW-1:0]) << 16);

  // The derivative magnitude saturates at 2^58; in StSat the product holds the
  // upper partial product.
  assign dsat    = |prod[ProdW-1:HiKeep];
  assign dsum    = (SatBit+1)'({prod[HiKeep-1:0], {MulW{1'b0}}}) + (SatBit+1)'(lo_q);
  assign dmag    = (dsat || (dsum > DerivLimit)) ? DerivLimit : dsum;
  assign dterm_d = dneg_q ? -TurnW'(dmag) : TurnW'(dmag);

  assign base_q     = {{(TurnW-DutyW-FracW){1'b0}}, cfg.base_speed, {FracW{1'b0}}};
  assign duty_a_q32 = base_q - turn_q;
  assign duty_b_q32 = base_q + turn_q;

  assign out_load = (state_q == StOut) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (accept) state_d = StProp;
      StProp:  state_d = StDeriv;
      StDeriv: state_d = StLo;
      StLo:    state_d = StHi;
      StHi:    state_d = StSat;
      StSat:   state_d = StTurn;
      StTurn:  state_d = StOut;
      StOut:   if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        prev_q <= line_error_i;
      end
      if (out_load) begin
        out_valid_q <= emit_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      eneg_q  <= line_error_i[ErrW-1];
      eabs_q  <= line_error_i[ErrW-1] ? ErrW'(-line_error_i) : ErrW'(line_error_i);
      step_q  <= time_step_i;
      dneg_q  <= diff[DiffW-1];
      adiff_q <= diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
      emit_q  <= in_band || spin_pos || spin_neg;
      mode_q  <= in_band ? ModeTrack : (spin_pos ? ModeSpinPos : ModeSpinNeg);
    end
    if (state_q == StDeriv) begin
      pterm_q <= pterm_d;
    end
    if (state_q == StLo) begin
      mhi_q <= prod[ProdW-1:MulW];
    end
    if (state_q == StHi) begin
      lo_q <= prod;
    end
    if (state_q == StSat) begin
      dterm_q <= dterm_d;
    end
    if (state_q == StTurn) begin
      turn_q <= pterm_q + dterm_q;
    end
    if (out_load) begin
      out_mode_q <= mode_q;
      unique case (mode_q)
        ModeTrack: begin
          a_dir_q  <= 1'b1;
          b_dir_q  <= 1'b0;
          a_duty_q <= clamp_duty(duty_a_q32);
          b_duty_q <= clamp_duty(duty_b_q32);
        end
        ModeSpinPos: begin
          a_dir_q  <= 1'b0;
          b_dir_q  <= 1'b0;
          a_duty_q <= cfg.spin_speed;
          b_duty_q <= cfg.spin_speed;
        end
        default: begin
          a_dir_q  <= 1'b1;
          b_dir_q  <= 1'b1;
          a_duty_q <= cfg.spin_speed;
          b_duty_q <= cfg.spin_speed;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign motor_a_dir_o  = a_dir_q;
  assign motor_b_dir_o  = b_dir_q;
  assign motor_a_duty_o = a_duty_q;
  assign motor_b_duty_o = b_duty_q;
  assign drive_mode_o   = out_mode_q;

endmodule

FILE: rtl/core/pdlf_cfg.sv
// ----------------------------------------------------------------------------
// PD line follower configuration registers
// Holds the gains, speeds and spin threshold written through the write port.
// ----------------------------------------------------------------------------
module pdlf_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pdlf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pdlf_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output pdlf_pkg::cfg_t                 cfg_o
);
  import pdlf_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgPropGain:  cfg_d.prop_gain      = cfg_wdata_i[GainW-1:0];
        CfgDerivGain: cfg_d.deriv_gain     = cfg_wdata_i[GainW-1:0];
        CfgBaseSpeed: cfg_d.base_speed     = cfg_wdata_i[DutyW-1:0];
        CfgSpinSpeed: cfg_d.spin_speed     = cfg_wdata_i[DutyW-1:0];
        CfgSpinThr:   cfg_d.spin_threshold = cfg_wdata_i[ThrW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain      <= GainW'(1311);
      cfg_q.deriv_gain     <= GainW'(393216);
      cfg_q.base_speed     <= DutyW'(40);
      cfg_q.spin_speed     <= DutyW'(35);
      cfg_q.spin_threshold <= ThrW'(3400);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/pdlf_mul.sv
// ----------------------------------------------------------------------------
// PD line follower shared multiplier
// Unsigned 24 x 24 multiplier with a registered product, reused for each multiply step.
// ----------------------------------------------------------------------------
module pdlf_mul (
  input  logic                        clk_i,
  input  pdlf_pkg::mul_req_t          req_i,
  output logic [pdlf_pkg::ProdW-1:0]  prod_o
);
  import pdlf_pkg::*;

  logic [ProdW-1:0] prod_q, prod_d;

  assign prod_d = ProdW'(req_i.op_a) * ProdW'(req_i.op_b);

  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule
